FILE: design/ordered_unique_key_set_defines.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ORDERED_UNIQUE_KEY_SET_DEFINES_SVH
`define ORDERED_UNIQUE_KEY_SET_DEFINES_SVH

// Same-cycle implication.
`define OUKS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered_unique_key_set: assertion failed");

// Next-cycle implication.
`define OUKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered_unique_key_set: assertion failed");

`endif

FILE: design/ouks_pkg.sv
package ouks_pkg;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned HandleW = 12;
  localparam int unsigned CountW  = 7;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_POP    = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [CoordW-1:0]  coord_x;
    logic signed [CoordW-1:0]  coord_y;
    logic [HandleW-1:0]        entry_handle;
  } ouks_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [HandleW-1:0] found_handle;
    logic [CountW-1:0]  entry_count;
  } ouks_res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } ouks_key_t;

  typedef struct packed {
    ouks_key_t          key;
    logic [HandleW-1:0] handle;
  } ouks_entry_t;

  typedef struct packed {
    logic        hit;
    ouks_entry_t entry;
  } ouks_rsp_t;

endpackage

FILE: design/ouks_table.sv
module ouks_table #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  ouks_pkg::ouks_entry_t wr_data_i,
  input  ouks_pkg::ouks_key_t key_i,
  output ouks_pkg::ouks_rsp_t rsp_o
);
  import ouks_pkg::*;

  ouks_entry_t mem [DEPTH];
  ouks_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rsp_o.entry = rd_q;
  assign rsp_o.hit   = (rd_q.key.coord_x == key_i.coord_x) &&
                       (rd_q.key.coord_y == key_i.coord_y);

endmodule

FILE: design/ordered_unique_key_set.sv
// Operation: result strobe in the cycle after the accepting edge on an empty table;
//   otherwise a lookup scans the held entries in order, and a remove at position p then
//   moves each later entry down one place. One entry is read from the table per cycle.
// Throughput: one transaction at a time; start is taken again in the strobe cycle.
// Reset: entry count cleared at once; table contents are not cleared and never read
//   beyond the held count. The receiver cannot stall the result.
module ordered_unique_key_set #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ouks_pkg::ouks_cmd_t cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output ouks_pkg::ouks_res_t res_o
);
  import ouks_pkg::*;
  `include "ordered_unique_key_set_defines.svh"

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  ouks_cmd_t       op_q, op_d;
  logic            done_q, done_d;
  ouks_res_t       res_q, res_d;

  logic             rd_en, wr_en, fin;
  logic [AddrW-1:0] rd_addr, wr_addr;
  ouks_entry_t      wr_data;
  ouks_key_t        key;
  ouks_rsp_t        rsp;
  logic [CntW-1:0]  idx_nx, idx_nx2;
  logic             hit_now;

  assign key.coord_x = op_q.coord_x;
  assign key.coord_y = op_q.coord_y;
  assign idx_nx  = CntW'(idx_q) + CntW'(1);
  assign idx_nx2 = CntW'(idx_q) + CntW'(2);
  assign hit_now = (op_q.cmd == CMD_POP) || rsp.hit;

  ouks_table #(
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .key_i    (key),
    .rsp_o    (rsp)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    op_d    = op_q;
    res_d   = res_q;
    fin     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d = cmd_i;
          res_d.found_handle = '0;
          if (cnt_q == '0) begin
            fin = 1'b1;
            if (cmd_i.cmd == CMD_INSERT) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data.key.coord_x = cmd_i.coord_x;
              wr_data.key.coord_y = cmd_i.coord_y;
              wr_data.handle      = cmd_i.entry_handle;
              cnt_d   = CntW'(1);
              res_d.status = STATUS_OK;
            end else begin
              res_d.status = STATUS_MISS;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          res_d.found_handle = rsp.entry.handle;
          unique case (op_q.cmd)
            CMD_INSERT: begin
              res_d.status = STATUS_MISS;
              fin = 1'b1;
            end
            CMD_FIND: begin
              res_d.status = STATUS_OK;
              fin = 1'b1;
            end
            default: begin
              res_d.status = STATUS_OK;
              if (idx_nx == cnt_q) begin
                cnt_d = cnt_q - CntW'(1);
                fin   = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = idx_nx[AddrW-1:0];
                state_d = ST_SHIFT;
              end
            end
          endcase
        end else if (idx_nx == cnt_q) begin
          fin = 1'b1;
          res_d.found_handle = '0;
          if (op_q.cmd == CMD_INSERT) begin
            if (cnt_q == CntW'(DEPTH)) begin
              res_d.status = STATUS_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[AddrW-1:0];
              wr_data.key    = key;
              wr_data.handle = op_q.entry_handle;
              cnt_d   = cnt_q + CntW'(1);
              res_d.status = STATUS_OK;
            end
          end else begin
            res_d.status = STATUS_MISS;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_nx[AddrW-1:0];
          idx_d   = idx_nx[AddrW-1:0];
        end
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rsp.entry;
        if (idx_nx2 == cnt_q) begin
          cnt_d = cnt_q - CntW'(1);
          fin   = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_nx2[AddrW-1:0];
          idx_d   = idx_nx[AddrW-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_d = ST_IDLE;
      res_d.entry_count = CountW'(cnt_d);
    end
    done_d = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    op_q  <= op_d;
    res_q <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `OUKS_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CntW'(DEPTH))
  `OUKS_ASSERT(a_done_cause, done_o, $past(busy_o) || $past(start_i))
  `OUKS_ASSERT(a_idle_write, wr_en && (state_q == ST_IDLE), cnt_q == '0)
  `OUKS_ASSERT(a_shift_range, state_q == ST_SHIFT, idx_nx2 <= cnt_q)
  `OUKS_ASSERT_NEXT(a_full_cnt, fin && (res_d.status == STATUS_FULL),
                    cnt_q == CntW'(DEPTH))

endmodule
